@@ hw/rtl/fca_pkg.sv @@
// Shared constants, types and widths for the frame cumulative average block.
// No dependencies; every other file of the block uses this package.
package fca_pkg;

    // Frame geometry and frame counter width
    localparam int FRAME_WIDTH   = 320;
    localparam int FRAME_HEIGHT  = 240;
    localparam int COUNT_BITS    = 16;
    localparam int PIXELS        = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_BITS     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // Channel and divider widths
    localparam int CHAN_BITS     = 8;
    localparam int NUM_BITS      = COUNT_BITS + CHAN_BITS;
    localparam int DEN_BITS      = COUNT_BITS + 1;
    localparam int DIV_STEPS     = CHAN_BITS;
    localparam int LANE_LAT      = DIV_STEPS + 1;
    localparam int LANES         = 3;
    localparam int STORE_BITS    = LANES * CHAN_BITS;

    // Output queue
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ADDR_BITS-1:0]  LAST_POS  = ADDR_BITS'(PIXELS - 1);

    typedef logic [CHAN_BITS-1:0]  chan_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [STORE_BITS-1:0] store_word_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        logic  last;
    } avg_word_t;

endpackage

@@ hw/rtl/fca_if.sv @@
// Valid/ready channel interfaces for the pixel input and the average output.
// Depends on fca_pkg for the channel type.
interface fca_pix_if;
    logic             valid;
    logic             ready;
    fca_pkg::chan_t   red_in;
    fca_pkg::chan_t   green_in;
    fca_pkg::chan_t   blue_in;
    fca_pkg::chan_t   alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface fca_avg_if;
    logic             valid;
    logic             ready;
    fca_pkg::chan_t   red_avg;
    fca_pkg::chan_t   green_avg;
    fca_pkg::chan_t   blue_avg;
    fca_pkg::chan_t   alpha_out;
    logic             frame_last;

    modport source (output valid, output red_avg, output green_avg, output blue_avg,
                    output alpha_out, output frame_last, input ready);
    modport sink   (input valid, input red_avg, input green_avg, input blue_avg,
                    input alpha_out, input frame_last, output ready);
endinterface

@@ hw/rtl/frame_cumulative_average_top.sv @@
// Per-pixel cumulative moving average over a frame store, one word per cycle while
// input is not stalled. From input accept to output valid: accept stage, product,
// eight divide stages, output queue write. The store's one read and one write port
// set one pixel per cycle; input stalls only while 16 words are in flight.
// Reset clears position and frame count; the store is not cleared, since the first
// frame (n = 0) ignores every value read and writes every entry.
module frame_cumulative_average_top (
    input  logic      clk,
    input  logic      rst_n,
    fca_pix_if.sink   pix,
    fca_avg_if.source avg
);
    import fca_pkg::*;

    typedef struct packed {
        addr_t pos;
        chan_t alpha;
        logic  last;
    } side_t;

    addr_t       pos_reg, pos_next;
    count_t      frames_reg, frames_next;
    logic        take;
    logic        room;
    logic        at_last;

    store_word_t store_mem [PIXELS];
    store_word_t rd_data_reg;

    logic        s1_vld_reg;
    chan_t       s1_red_reg, s1_green_reg, s1_blue_reg;
    count_t      s1_n_reg;
    side_t       s1_side_reg;
    side_t       side_reg [LANE_LAT];

    logic [LANES-1:0] lane_vld;
    chan_t       lane_pix [LANES];
    chan_t       lane_old [LANES];
    chan_t       lane_q   [LANES];
    side_t       side_out;

    assign take      = pix.valid && room;
    assign pix.ready = room;
    assign at_last   = (pos_reg == LAST_POS);

    // Pixel position and completed frame count
    always_comb
    begin
        pos_next    = pos_reg;
        frames_next = frames_reg;
        if (take)
        begin
            if (at_last)
            begin
                pos_next = '0;
                if (frames_reg != COUNT_MAX)
                begin
                    frames_next = frames_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            frames_reg <= frames_next;
            s1_vld_reg <= take;
        end
    end

    // Accept stage: capture pixel and frame weight
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_red_reg        <= pix.red_in;
            s1_green_reg      <= pix.green_in;
            s1_blue_reg       <= pix.blue_in;
            s1_n_reg          <= frames_reg;
            s1_side_reg.pos   <= pos_reg;
            s1_side_reg.alpha <= pix.alpha_in;
            s1_side_reg.last  <= at_last;
        end
    end

    // Average store: read on accept, write back when the lanes finish
    assign side_out = side_reg[LANE_LAT-1];

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_data_reg <= store_mem[pos_reg];
        end
        if (&lane_vld)
        begin
            store_mem[side_out.pos] <= {lane_q[2], lane_q[1], lane_q[0]};
        end
    end

    // Side information travels beside the lanes
    always_ff @(posedge clk)
    begin
        side_reg[0] <= s1_side_reg;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Channel lanes
    assign lane_pix[0] = s1_red_reg;
    assign lane_pix[1] = s1_green_reg;
    assign lane_pix[2] = s1_blue_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign lane_old[l] = rd_data_reg[l*CHAN_BITS +: CHAN_BITS];

        fca_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s1_vld_reg),
            .pix       (lane_pix[l]),
            .old       (lane_old[l]),
            .n         (s1_n_reg),
            .out_valid (lane_vld[l]),
            .quot      (lane_q[l])
        );
    end

    // Merge and output queue
    fca_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (take),
        .room     (room),
        .lane_vld (lane_vld),
        .lane_q   (lane_q),
        .alpha    (side_out.alpha),
        .last     (side_out.last),
        .avg      (avg)
    );

endmodule

@@ hw/rtl/fca_lane.sv @@
// One channel lane: forms pix + n*old, then a restoring divide by n+1,
// one quotient bit per pipeline stage. Depends on fca_pkg.
module fca_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  fca_pkg::chan_t  pix,
    input  fca_pkg::chan_t  old,
    input  fca_pkg::count_t n,
    output logic            out_valid,
    output fca_pkg::chan_t  quot
);
    import fca_pkg::*;

    logic [DIV_STEPS:0]  vld_reg;
    logic [NUM_BITS-1:0] rem_reg [DIV_STEPS+1];
    logic [DEN_BITS-1:0] den_reg [DIV_STEPS+1];
    chan_t               q_reg   [1:DIV_STEPS];
    logic [NUM_BITS-1:0] prod;

    // Numerator and divisor stage; with no completed frames the stored value
    // carries no weight and is not looked at
    assign prod = (n == '0) ? '0 : NUM_BITS'(n) * NUM_BITS'(old);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= prod + NUM_BITS'(pix);
        den_reg[0] <= DEN_BITS'(n) + DEN_BITS'(1);
    end

    // Divide stages, most significant quotient bit first
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        localparam int B = DIV_STEPS - k;
        logic [NUM_BITS-1:0] trial;
        logic                hit;
        chan_t               q_prev;
        chan_t               q_next;

        assign trial = NUM_BITS'(den_reg[k-1]) << B;
        assign hit   = (rem_reg[k-1] >= trial);

        if (k == 1)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = q_reg[k-1];
        end

        always_comb
        begin
            q_next    = q_prev;
            q_next[B] = hit;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= hit ? (rem_reg[k-1] - trial) : rem_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            q_reg[k]   <= q_next;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign quot      = q_reg[DIV_STEPS];

endmodule

@@ hw/rtl/fca_merge.sv @@
// Merge stage: packs the lane quotients with alpha and frame end into one word,
// queues it, and tracks words in flight for input flow control. Depends on fca_pkg.
module fca_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    output logic                 room,
    input  logic [fca_pkg::LANES-1:0] lane_vld,
    input  fca_pkg::chan_t       lane_q [fca_pkg::LANES],
    input  fca_pkg::chan_t       alpha,
    input  logic                 last,
    fca_avg_if.source            avg
);
    import fca_pkg::*;

    avg_word_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [FIFO_CNT_BITS-1:0] occ_reg, occ_next;
    logic                     push;
    logic                     pop;
    avg_word_t                push_word;
    avg_word_t                head;

    // Combine lanes into one result word
    assign push = &lane_vld;
    always_comb
    begin
        push_word.red   = lane_q[0];
        push_word.green = lane_q[1];
        push_word.blue  = lane_q[2];
        push_word.alpha = alpha;
        push_word.last  = last;
    end

    assign pop  = avg.valid && avg.ready;
    // Words accepted but not yet delivered never exceed the queue depth
    assign room = (occ_reg < FIFO_CNT_BITS'(FIFO_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
        occ_next    = occ_reg + FIFO_CNT_BITS'(in_take) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            occ_reg    <= occ_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
    end

    // Output side
    assign head           = fifo_mem[rd_ptr_reg];
    assign avg.valid      = (cnt_reg != '0);
    assign avg.red_avg    = head.red;
    assign avg.green_avg  = head.green;
    assign avg.blue_avg   = head.blue;
    assign avg.alpha_out  = head.alpha;
    assign avg.frame_last = head.last;

endmodule
